// File: src/bstk_pkg.sv
// Shared constants and types for the bounded stack with merge.
`default_nettype none
package bstk_pkg;

  localparam int DepthDefault     = 8;
  localparam int DataWidthDefault = 16;
  localparam int StatusWidth      = 3;
  localparam int ReqWidth         = 2;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_MERGED = 3'd3,
    ST_PUSHED = 3'd4
  } status_t;

  localparam logic [ReqWidth-1:0] REQ_PUSH = 2'd0;
  localparam logic [ReqWidth-1:0] REQ_POP  = 2'd1;
  localparam logic [ReqWidth-1:0] REQ_DUMP = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PREV = 2'd1,
    CELL_NEXT = 2'd2
  } cell_op_t;

endpackage
`default_nettype wire

// File: src/bstk_cell.sv
// One stack cell: holds an entry, loads from the cell above or below.
`default_nettype none
module bstk_cell #(
  parameter int WIDTH = bstk_pkg::DataWidthDefault
) (
  input  wire                   clk,
  input  bstk_pkg::cell_op_t    op,
  input  wire  [WIDTH-1:0]      prev_data,
  input  wire  [WIDTH-1:0]      next_data,
  output logic [WIDTH-1:0]      data
);

  always_ff @(posedge clk) begin
    case (op)
      bstk_pkg::CELL_PREV: data <= prev_data;
      bstk_pkg::CELL_NEXT: data <= next_data;
      default:             data <= data;
    endcase
  end

endmodule
`default_nettype wire

// File: src/bounded_stack_with_merge_unit.sv
// Top level: bounded LIFO stack with push merge, built as a chain of cells.
//
// Usage: requests enter on in_valid/in_stall with req_type and push_value;
// results leave on out_valid/out_stall with data_out, status, level, last.
// A transaction happens at a clock edge where valid is high and stall low.
// The entries sit in a chain of cells, top of stack in cell 0; push shifts
// the chain down, pop and merge shift it up.
// Push and pop: the result is registered at the accepting edge and is valid
// in the next cycle; one request per cycle while the output is taken.
// Dump: the chain rotates one full turn, the last cell feeding cell 0; the
// garbage cells pass first, then the held entries leave bottom first; input
// is stalled for the whole rotation plus any output stall.
// An unused request code is accepted and gives no result. merge_mode is
// written through cfg_we/cfg_wdata; the user must do so only while the
// block is idle, which the block does not check. Reset (rst, synchronous)
// empties the stack and clears merge_mode; cell contents are not cleared.
// While out_stall is high the result holds, dump output and input pause.
`default_nettype none
module bounded_stack_with_merge_unit #(
  parameter int DEPTH      = bstk_pkg::DepthDefault,
  parameter int DATA_WIDTH = bstk_pkg::DataWidthDefault,
  parameter int LEVEL_W    = $clog2(DEPTH + 1)
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_we,
  input  wire                               cfg_wdata,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  [bstk_pkg::ReqWidth-1:0]     req_type,
  input  wire  [DATA_WIDTH-1:0]             push_value,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [DATA_WIDTH-1:0]             data_out,
  output logic [bstk_pkg::StatusWidth-1:0]  status,
  output logic [LEVEL_W-1:0]                level,
  output logic                              last
);

  typedef enum logic {S_IDLE, S_DUMP} state_t;

  localparam logic [LEVEL_W-1:0] DepthVal = LEVEL_W'(DEPTH);
  localparam logic [LEVEL_W-1:0] LastRot  = LEVEL_W'(DEPTH - 1);

  state_t                 state, state_next;
  logic                   merge_mode;
  logic [LEVEL_W-1:0]     count, count_next;
  logic [LEVEL_W-1:0]     rot_cnt, rot_cnt_next;
  logic                   emit;
  logic [DATA_WIDTH-1:0]  emit_data;
  bstk_pkg::status_t      emit_status;
  logic                   emit_last;
  logic                   out_free;
  logic                   accept;
  logic                   push_stored;
  bstk_pkg::cell_op_t     cell_op;
  logic [DATA_WIDTH-1:0]  head_in;
  logic [DATA_WIDTH-1:0]  cell_q [DEPTH];

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !(state == S_IDLE && out_free);
  assign accept   = in_valid && !in_stall;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      bstk_cell #(.WIDTH(DATA_WIDTH)) u_cell (
        .clk       (clk),
        .op        (cell_op),
        .prev_data ((gi == 0) ? head_in : cell_q[(gi == 0) ? 0 : gi - 1]),
        .next_data (cell_q[(gi == DEPTH - 1) ? gi : gi + 1]),
        .data      (cell_q[gi])
      );
    end
  endgenerate

  always_comb begin
    state_next   = state;
    count_next   = count;
    rot_cnt_next = rot_cnt;
    emit         = 1'b0;
    emit_data    = '0;
    emit_status  = bstk_pkg::ST_OK;
    emit_last    = 1'b1;
    cell_op      = bstk_pkg::CELL_HOLD;
    head_in      = push_value;
    push_stored  = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_type)
            bstk_pkg::REQ_PUSH: begin
              emit = 1'b1;
              if (merge_mode && count != '0 && cell_q[0] == push_value) begin
                emit_status = bstk_pkg::ST_MERGED;
                cell_op     = bstk_pkg::CELL_NEXT;
                count_next  = count - 1'b1;
              end else if (count == DepthVal) begin
                emit_status = bstk_pkg::ST_FULL;
              end else begin
                emit_status = bstk_pkg::ST_PUSHED;
                cell_op     = bstk_pkg::CELL_PREV;
                count_next  = count + 1'b1;
                push_stored = 1'b1;
              end
            end
            bstk_pkg::REQ_POP: begin
              emit = 1'b1;
              if (count == '0) begin
                emit_status = bstk_pkg::ST_EMPTY;
              end else begin
                emit_data  = cell_q[0];
                cell_op    = bstk_pkg::CELL_NEXT;
                count_next = count - 1'b1;
              end
            end
            bstk_pkg::REQ_DUMP: begin
              if (count == '0) begin
                emit        = 1'b1;
                emit_status = bstk_pkg::ST_EMPTY;
              end else begin
                state_next   = S_DUMP;
                rot_cnt_next = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_DUMP: begin
        head_in = cell_q[DEPTH-1];
        if ((LEVEL_W + 1)'(rot_cnt) + (LEVEL_W + 1)'(count) < (LEVEL_W + 1)'(DEPTH)) begin
          // garbage cells below the bottom entry pass by without output
          cell_op      = bstk_pkg::CELL_PREV;
          rot_cnt_next = rot_cnt + 1'b1;
        end else if (out_free) begin
          emit         = 1'b1;
          emit_data    = cell_q[DEPTH-1];
          emit_last    = (rot_cnt == LastRot);
          cell_op      = bstk_pkg::CELL_PREV;
          rot_cnt_next = rot_cnt + 1'b1;
          if (rot_cnt == LastRot) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      rot_cnt    <= '0;
      merge_mode <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      rot_cnt <= rot_cnt_next;
      if (cfg_we) begin
        merge_mode <= cfg_wdata;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (emit) begin
      data_out <= emit_data;
      status   <= emit_status;
      level    <= count_next;
      last     <= emit_last;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DepthVal)
    else $error("fill count above depth");

  a_dump_stalls: assert property (@(posedge clk) disable iff (rst)
    state == S_DUMP |-> in_stall)
    else $error("input open during dump");

  a_dump_keeps_count: assert property (@(posedge clk) disable iff (rst)
    state == S_DUMP |=> count == $past(count))
    else $error("dump changed fill count");

  a_push_lands_top: assert property (@(posedge clk) disable iff (rst)
    push_stored |=> cell_q[0] == $past(push_value))
    else $error("pushed value not on top");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result overwritten while stalled");

endmodule
`default_nettype wire
